// ----- src/bc_pkg.sv -----
// Shared constants for the barycentric weight pipeline.
package bc_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int WEIGHT_FRAC_BITS = 16;
	localparam int INT_BITS         = 4;

	localparam int EDGE_W = COORD_WIDTH + 1;
	localparam int DOT_W  = 2 * EDGE_W + 2;
	localparam int PROD_W = 2 * DOT_W;
	localparam int NUM_W  = PROD_W + 1;
	localparam int QUO_W  = NUM_W + WEIGHT_FRAC_BITS;

endpackage

// ----- src/barycentric_coordinates.sv -----
// Barycentric weights of a point against a 3D triangle: top level pipeline.
//
// Input channel: valid/stall with twelve Q12.4 coordinates (vertices A, B, C
// and the query point). Result channel: res_valid/res_stall with weights u, v,
// w in Q4.16 plus degenerate and saturated flags. One result word per input word.
// Fully pipelined: one word enters every cycle while the pipeline is not frozen.
// The depth is set mostly by the divider, which retires one quotient bit per
// stage over the whole scaled numerator; it follows the difference, product,
// dot product, three stage multiply, determinant and magnitude stages, and the
// weight and clamp stages follow it.
// The whole pipeline advances together; while a result is held by res_stall the
// pipeline freezes and stall is raised to the sender, so nothing is lost or
// repeated. Bubbles stay in place while frozen.
// Reset clears the valid bits only; the datapath carries no reset.
// A zero determinant gives zero weights with degenerate set; out of range
// weights clamp and set saturated.
module barycentric_coordinates #(
	parameter int COORD_WIDTH      = bc_pkg::COORD_WIDTH,
	parameter int WEIGHT_FRAC_BITS = bc_pkg::WEIGHT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic stall,
	input  logic signed [COORD_WIDTH-1:0] vert_a_x,
	input  logic signed [COORD_WIDTH-1:0] vert_a_y,
	input  logic signed [COORD_WIDTH-1:0] vert_a_z,
	input  logic signed [COORD_WIDTH-1:0] vert_b_x,
	input  logic signed [COORD_WIDTH-1:0] vert_b_y,
	input  logic signed [COORD_WIDTH-1:0] vert_b_z,
	input  logic signed [COORD_WIDTH-1:0] vert_c_x,
	input  logic signed [COORD_WIDTH-1:0] vert_c_y,
	input  logic signed [COORD_WIDTH-1:0] vert_c_z,
	input  logic signed [COORD_WIDTH-1:0] query_x,
	input  logic signed [COORD_WIDTH-1:0] query_y,
	input  logic signed [COORD_WIDTH-1:0] query_z,
	output logic res_valid,
	input  logic res_stall,
	output logic signed [WEIGHT_FRAC_BITS+bc_pkg::INT_BITS-1:0] weight_u,
	output logic signed [WEIGHT_FRAC_BITS+bc_pkg::INT_BITS-1:0] weight_v,
	output logic signed [WEIGHT_FRAC_BITS+bc_pkg::INT_BITS-1:0] weight_w,
	output logic degenerate,
	output logic saturated
);

	localparam int F   = WEIGHT_FRAC_BITS;
	localparam int OW  = F + bc_pkg::INT_BITS;
	localparam int EW  = COORD_WIDTH + 1;
	localparam int DW  = 2 * EW + 2;
	localparam int PW  = 2 * DW;
	localparam int NW  = PW + 1;
	localparam int N   = NW + F;
	localparam int L   = N + 10;

	localparam int VA [5] = '{0, 0, 1, 2, 2};
	localparam int VB [5] = '{0, 1, 1, 0, 1};
	localparam int MA [6] = '{0, 1, 2, 1, 0, 1};
	localparam int MB [6] = '{2, 1, 3, 4, 4, 3};

	localparam logic signed [N+2:0] ONE = (N+3)'(1) << F;
	localparam logic signed [N+2:0] HI  = ((N+3)'(1) << (OW - 1)) - (N+3)'(1);
	localparam logic signed [N+2:0] LO  = -HI - (N+3)'(1);

	logic en;
	logic [L-1:0] vld_q;

	logic signed [COORD_WIDTH-1:0] crd [12];
	logic signed [EW-1:0]   e_s1   [9];
	logic signed [2*EW-1:0] prod_s2 [15];
	logic signed [DW-1:0]   dot_s3 [5];
	logic signed [PW-1:0]   p_m    [6];
	logic signed [PW-1:0]   det_s7;
	logic signed [NW-1:0]   nv_s7, nw_s7;
	logic [PW-1:0]          den_s8;
	logic [NW-1:0]          magv_s8, magw_s8;
	logic                   negv_s8, negw_s8, deg_s8;
	logic [N-1:0]           qv_d, qw_d;
	logic [1:0]             tagv_d;
	logic                   tagw_d;
	logic signed [N:0]      qv_c, qw_c, qv_n, qw_n;
	logic signed [N:0]      qv_s9, qw_s9;
	logic signed [N+2:0]    qu_s9;
	logic                   deg_s9;
	logic signed [N+2:0]    wx   [3];
	logic [2:0]             hi_c, lo_c;
	logic signed [OW-1:0]   w_s10 [3];
	logic                   deg_s10, sat_s10;

	assign en    = !(vld_q[L-1] && res_stall);
	assign stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], valid};
		end
	end

	assign crd = '{vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
		vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z};

	// edges, products, dot products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				e_s1[j] <= EW'(crd[j+3]) - EW'(crd[j%3]);
			end
			for (int k = 0; k < 5; k++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[k*3+c] <= e_s1[VA[k]*3+c] * e_s1[VB[k]*3+c];
				end
			end
			for (int k = 0; k < 5; k++) begin
				dot_s3[k] <= DW'(prod_s2[k*3]) + DW'(prod_s2[k*3+1]) + DW'(prod_s2[k*3+2]);
			end
		end
	end

	for (genvar i = 0; i < 6; i++) begin : g_mul
		bc_mul #(.W(DW)) u_mul (
			.clk (clk),
			.en  (en),
			.a   (dot_s3[MA[i]]),
			.b   (dot_s3[MB[i]]),
			.p   (p_m[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s7  <= p_m[0] - p_m[1];
			nv_s7   <= NW'(p_m[2]) - NW'(p_m[3]);
			nw_s7   <= NW'(p_m[4]) - NW'(p_m[5]);
			deg_s8  <= det_s7 == '0;
			den_s8  <= $unsigned(det_s7);
			negv_s8 <= nv_s7[NW-1];
			negw_s8 <= nw_s7[NW-1];
			magv_s8 <= nv_s7[NW-1] ? $unsigned(-nv_s7) : $unsigned(nv_s7);
			magw_s8 <= nw_s7[NW-1] ? $unsigned(-nw_s7) : $unsigned(nw_s7);
		end
	end

	bc_div #(.N(N), .M(PW), .TAG_W(2)) u_div_v (
		.clk     (clk),
		.en      (en),
		.num     ({magv_s8, F'(0)}),
		.den     (den_s8),
		.tag_in  ({deg_s8, negv_s8}),
		.quo     (qv_d),
		.tag_out (tagv_d)
	);

	bc_div #(.N(N), .M(PW), .TAG_W(1)) u_div_w (
		.clk     (clk),
		.en      (en),
		.num     ({magw_s8, F'(0)}),
		.den     (den_s8),
		.tag_in  (negw_s8),
		.quo     (qw_d),
		.tag_out (tagw_d)
	);

	assign qv_c = $signed({1'b0, qv_d});
	assign qw_c = $signed({1'b0, qw_d});
	assign qv_n = tagv_d[0] ? -qv_c : qv_c;
	assign qw_n = tagw_d ? -qw_c : qw_c;

	always_ff @(posedge clk) begin
		if (en) begin
			qv_s9  <= qv_n;
			qw_s9  <= qw_n;
			qu_s9  <= ONE - (N+3)'(qv_n) - (N+3)'(qw_n);
			deg_s9 <= tagv_d[1];
		end
	end

	assign wx[0] = qu_s9;
	assign wx[1] = (N+3)'(qv_s9);
	assign wx[2] = (N+3)'(qw_s9);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hi_c[i] = wx[i] > HI;
			lo_c[i] = wx[i] < LO;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (deg_s9) begin
					w_s10[i] <= '0;
				end else if (hi_c[i]) begin
					w_s10[i] <= HI[OW-1:0];
				end else if (lo_c[i]) begin
					w_s10[i] <= LO[OW-1:0];
				end else begin
					w_s10[i] <= wx[i][OW-1:0];
				end
			end
			deg_s10 <= deg_s9;
			sat_s10 <= !deg_s9 && ((hi_c | lo_c) != 3'b000);
		end
	end

	assign res_valid  = vld_q[L-1];
	assign weight_u   = w_s10[0];
	assign weight_v   = w_s10[1];
	assign weight_w   = w_s10[2];
	assign degenerate = deg_s10;
	assign saturated  = sat_s10;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && degenerate |->
			weight_u == '0 && weight_v == '0 && weight_w == '0 && !saturated)
		else $error("degenerate word with nonzero weights");

	a_sum_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !degenerate && !saturated |->
			(OW+2)'(weight_u) + (OW+2)'(weight_v) + (OW+2)'(weight_w)
				== ((OW+2)'(1) << F))
		else $error("unclamped weights do not sum to one");

	a_sat_edge: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && saturated |->
			weight_u == HI[OW-1:0] || weight_u == LO[OW-1:0] ||
			weight_v == HI[OW-1:0] || weight_v == LO[OW-1:0] ||
			weight_w == HI[OW-1:0] || weight_w == LO[OW-1:0])
		else $error("saturated flag without a clamped weight");

endmodule

// ----- src/bc_mul.sv -----
// Three stage signed multiplier built from four half-width partial products.
module bc_mul #(
	parameter int W = bc_pkg::DOT_W
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	localparam int H = (W + 1) / 2;
	localparam int G = W - H;

	logic [W-1:0]     ma_s1, mb_s1;
	logic             neg_s1;
	logic [2*G-1:0]   hh_s2;
	logic [G+H-1:0]   hl_s2, lh_s2;
	logic [2*H-1:0]   ll_s2;
	logic             neg_s2;
	logic [2*W-1:0]   sum_c;
	logic signed [2*W-1:0] p_s3;

	assign sum_c = ((2*W)'(hh_s2) << (2*H)) + ((2*W)'(hl_s2) << H)
		+ ((2*W)'(lh_s2) << H) + (2*W)'(ll_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= a[W-1] ? $unsigned(-a) : $unsigned(a);
			mb_s1  <= b[W-1] ? $unsigned(-b) : $unsigned(b);
			neg_s1 <= a[W-1] ^ b[W-1];
			hh_s2  <= (2*G)'(ma_s1[W-1:H]) * (2*G)'(mb_s1[W-1:H]);
			hl_s2  <= (G+H)'(ma_s1[W-1:H]) * (G+H)'(mb_s1[H-1:0]);
			lh_s2  <= (G+H)'(ma_s1[H-1:0]) * (G+H)'(mb_s1[W-1:H]);
			ll_s2  <= (2*H)'(ma_s1[H-1:0]) * (2*H)'(mb_s1[H-1:0]);
			neg_s2 <= neg_s1;
			p_s3   <= neg_s2 ? -$signed(sum_c) : $signed(sum_c);
		end
	end

	assign p = p_s3;

endmodule

// ----- src/bc_div.sv -----
// Unsigned restoring divider, one quotient bit per pipeline stage, with sideband.
module bc_div #(
	parameter int N     = bc_pkg::QUO_W,
	parameter int M     = bc_pkg::PROD_W,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [N-1:0]     num,
	input  logic [M-1:0]     den,
	input  logic [TAG_W-1:0] tag_in,
	output logic [N-1:0]     quo,
	output logic [TAG_W-1:0] tag_out
);

	logic [M-1:0]     rem_s [N];
	logic [N-1:0]     dq_s  [N];
	logic [M-1:0]     den_s [N];
	logic [TAG_W-1:0] tag_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stg
		logic [M-1:0]     rem_i;
		logic [M-1:0]     den_i;
		logic [N-1:0]     dq_i;
		logic [TAG_W-1:0] tag_i;
		logic [M:0]       rem_t;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign den_i = den;
			assign dq_i  = num;
			assign tag_i = tag_in;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign dq_i  = dq_s[k-1];
			assign tag_i = tag_s[k-1];
		end

		assign rem_t = {rem_i, dq_i[N-1]};
		assign ge    = rem_t >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? M'(rem_t - {1'b0, den_i}) : rem_t[M-1:0];
				dq_s[k]  <= {dq_i[N-2:0], ge};
				den_s[k] <= den_i;
				tag_s[k] <= tag_i;
			end
		end
	end

	assign quo     = dq_s[N-1];
	assign tag_out = tag_s[N-1];

endmodule
